FILE: rtl/core/dfa_pkg.sv
// Shared types and constants for the table-driven DFA acceptor.
// Holds transaction payload structs, request codes and controller/datapath links.
// No dependencies.
package dfa_pkg;

  localparam int NUM_STATES = 256;
  localparam int MAX_MOVES  = 16;
  localparam int ADDR_W     = $clog2(NUM_STATES);
  localparam int CNT_W      = $clog2(MAX_MOVES + 1);
  localparam int MOVE_W     = 16;               // symbol and next state
  localparam int INFO_W     = CNT_W + 1;        // move count and accept flag

  localparam logic [1:0] REQ_MOVE = 2'd0;
  localparam logic [1:0] REQ_INFO = 2'd1;
  localparam logic [1:0] REQ_BYTE = 2'd2;
  localparam logic [1:0] REQ_END  = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] state_index;
    logic [3:0] move_slot;
    logic [4:0] n_moves;
    logic       accept;
    logic [7:0] symbol;
    logic [7:0] next_state;
  } dfa_in_t;

  typedef struct packed {
    logic matched;
    logic dead_end;
  } dfa_out_t;

  // Controller to datapath
  typedef struct packed {
    logic take;   // input transaction accepted this cycle
    logic step;   // evaluate the latched text request
  } dfa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic text_req;   // incoming request is a text byte or end of text
    logic eval_wait;  // verdict cannot be loaded yet, output still held
  } dfa_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } dfa_state_t;

endpackage

FILE: rtl/core/dfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/dfa_ctrl.sv
// Controller state machine of the DFA acceptor: accepts transactions and sequences evaluation.
// Depends on dfa_pkg.
module dfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dfa_pkg::dfa_sts_t sts,
  output dfa_pkg::dfa_cmd_t cmd
);

  dfa_pkg::dfa_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      dfa_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
        if (in_valid && sts.text_req) begin
          state_nxt = dfa_pkg::ST_EVAL;
        end
      end
      dfa_pkg::ST_EVAL: begin
        // hold an end of text while an earlier verdict is still stalled in the output register
        if (!sts.eval_wait) begin
          cmd.step  = 1'b1;
          state_nxt = dfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dfa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dfa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/dfa_dpath.sv
// Datapath of the DFA acceptor: move lanes, state info store, current state and verdict register.
// Depends on dfa_pkg and dfa_ram.
module dfa_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  dfa_pkg::dfa_in_t   in_data,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               out_stall,
  output logic               out_valid,
  output dfa_pkg::dfa_out_t  out_data,
  input  dfa_pkg::dfa_cmd_t  cmd,
  output dfa_pkg::dfa_sts_t  sts
);

  logic [7:0]                     start_r;
  logic [7:0]                     cur_r;
  logic                           rej_r;
  logic                           in_text_r;
  logic [1:0]                     req_r;
  logic [7:0]                     sym_r;
  logic                           rng_r;
  logic                           vld_q_r;
  logic [dfa_pkg::NUM_STATES-1:0] info_vld_r;
  logic                           out_valid_r;
  dfa_pkg::dfa_out_t              out_data_r;

  logic [7:0]                     rd_state;
  logic [dfa_pkg::ADDR_W-1:0]     rd_addr;
  logic [dfa_pkg::ADDR_W-1:0]     wr_addr;
  logic                           rd_rng;
  logic                           wr_rng;
  logic                           move_we;
  logic                           info_we;
  logic                           text_take;
  logic [dfa_pkg::CNT_W-1:0]      cnt_in;
  logic [dfa_pkg::INFO_W-1:0]     info_q;
  logic [dfa_pkg::CNT_W-1:0]      row_cnt;
  logic                           row_acc;
  logic [dfa_pkg::MOVE_W-1:0]     lane_q [dfa_pkg::MAX_MOVES];
  logic                           hit;
  logic [7:0]                     hit_next;
  logic                           ok;

  // Address of the row a text request reads: a new text starts at the start state
  assign rd_state  = in_text_r ? cur_r : start_r;
  assign rd_addr   = rd_state[dfa_pkg::ADDR_W-1:0];
  assign rd_rng    = 32'(rd_state) < 32'(dfa_pkg::NUM_STATES);
  assign wr_addr   = in_data.state_index[dfa_pkg::ADDR_W-1:0];
  assign wr_rng    = 32'(in_data.state_index) < 32'(dfa_pkg::NUM_STATES);
  assign text_take = cmd.take && (in_data.req_type == dfa_pkg::REQ_BYTE ||
                                  in_data.req_type == dfa_pkg::REQ_END);
  assign move_we   = cmd.take && in_data.req_type == dfa_pkg::REQ_MOVE && wr_rng &&
                     32'(in_data.move_slot) < 32'(dfa_pkg::MAX_MOVES);
  assign info_we   = cmd.take && in_data.req_type == dfa_pkg::REQ_INFO && wr_rng;

  // clamp oversized counts
  always_comb begin
    if (32'(in_data.n_moves) > 32'(dfa_pkg::MAX_MOVES)) begin
      cnt_in = dfa_pkg::CNT_W'(dfa_pkg::MAX_MOVES);
    end else begin
      cnt_in = dfa_pkg::CNT_W'(in_data.n_moves);
    end
  end

  // One RAM per move slot so a whole row compares in parallel
  for (genvar j = 0; j < dfa_pkg::MAX_MOVES; j++) begin : g_lane
    dfa_ram #(
      .WIDTH(dfa_pkg::MOVE_W),
      .DEPTH(dfa_pkg::NUM_STATES)
    ) u_lane (
      .clk  (clk),
      .we   (move_we && 32'(in_data.move_slot) == 32'(j)),
      .waddr(wr_addr),
      .wdata({in_data.symbol, in_data.next_state}),
      .re   (text_take),
      .raddr(rd_addr),
      .rdata(lane_q[j])
    );
  end

  dfa_ram #(
    .WIDTH(dfa_pkg::INFO_W),
    .DEPTH(dfa_pkg::NUM_STATES)
  ) u_info (
    .clk  (clk),
    .we   (info_we),
    .waddr(wr_addr),
    .wdata({cnt_in, in_data.accept}),
    .re   (text_take),
    .raddr(rd_addr),
    .rdata(info_q)
  );

  // unwritten info entries read as zero count, not accepting
  assign row_cnt = vld_q_r ? info_q[dfa_pkg::INFO_W-1:1] : '0;
  assign row_acc = vld_q_r & info_q[0];

  // first listed move wins: scan from the top so lower slots overwrite
  always_comb begin
    hit      = 1'b0;
    hit_next = '0;
    for (int j = dfa_pkg::MAX_MOVES - 1; j >= 0; j--) begin
      if (j < int'(row_cnt) && lane_q[j][15:8] == sym_r) begin
        hit      = 1'b1;
        hit_next = lane_q[j][7:0];
      end
    end
  end

  assign ok = !rej_r && rng_r && row_acc;

  always_ff @(posedge clk) begin
    if (text_take) begin
      req_r   <= in_data.req_type;
      sym_r   <= in_data.symbol;
      rng_r   <= rd_rng;
      vld_q_r <= info_vld_r[rd_addr];
    end
    if (cmd.step && req_r == dfa_pkg::REQ_END) begin
      out_data_r <= '{matched: ok, dead_end: rej_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      cur_r       <= '0;
      rej_r       <= 1'b0;
      in_text_r   <= 1'b0;
      info_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
      if (info_we) begin
        info_vld_r[wr_addr] <= 1'b1;
      end
      if (text_take && !in_text_r) begin
        cur_r     <= start_r;
        rej_r     <= 1'b0;
        in_text_r <= 1'b1;
      end
      if (cmd.step) begin
        if (req_r == dfa_pkg::REQ_END) begin
          in_text_r <= 1'b0;
          rej_r     <= 1'b0;
          cur_r     <= start_r;
        end else if (!rej_r) begin
          if (rng_r && hit) begin
            cur_r <= hit_next;
          end else begin
            rej_r <= 1'b1;
          end
        end
      end
      if (cmd.step && req_r == dfa_pkg::REQ_END) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.text_req  = in_data.req_type == dfa_pkg::REQ_BYTE ||
                         in_data.req_type == dfa_pkg::REQ_END;
  assign sts.eval_wait = req_r == dfa_pkg::REQ_END && out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/dfa_string_acceptor.sv
// Top level of the table-driven DFA string acceptor.
// Depends on dfa_pkg, dfa_ctrl, dfa_dpath (and dfa_ram through the datapath).
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   dfa_pkg::dfa_in_t  (load, byte or end request)
//   out      output     out_valid / out_stall dfa_pkg::dfa_out_t (verdict per end of text)
//   cfg      input      cfg_wr_en             cfg_wr_data: start state
//
// Load transactions (move entry, state info) are written as they are accepted.
// Text bytes and end-of-text are accepted in IDLE, which reads the current state's
// row from the move lanes and info store; EVAL then compares all slots and steps.
// Reset clears the state info valid bits at once, so no clearing pass is needed.
// An end of text holds in evaluation while a previous verdict is stalled on out.
module dfa_string_acceptor (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  dfa_pkg::dfa_in_t  in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output dfa_pkg::dfa_out_t out_data,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  dfa_pkg::dfa_cmd_t cmd;
  dfa_pkg::dfa_sts_t sts;

  // Sequence accept and evaluation
  dfa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Hold the table, walk the automaton, register the verdict
  dfa_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
